[hw/rtl/wpm_pkg.sv]
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types and codes for the wildcard pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [7:0] byte_t;

  localparam mode_t MODE_CLEAR  = 2'd0;
  localparam mode_t MODE_APPEND = 2'd1;
  localparam mode_t MODE_TEXT   = 2'd2;
  localparam mode_t MODE_END    = 2'd3;

  localparam byte_t STAR_BYTE = 8'h2A;
  localparam byte_t ANY_BYTE  = 8'h3F;

  // pattern update command from the item stage
  typedef struct packed {
    logic  clear;
    logic  append;
    byte_t symbol;
  } pat_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/wpm_pattern.sv]
// ----------------------------------------------------------------------------
// wpm_pattern
// Pattern store with a one-hot end pointer, a position mask and the sticky
// overflow flag; each position exposes its own byte and star/any decode.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_pattern #(
  parameter int MAX_PATTERN = 128
) (
  input  logic                        clk,
  input  logic                        rst,
  input  wpm_pkg::pat_cmd_t           cmd,
  output logic [MAX_PATTERN-1:0]      mask,
  output logic [MAX_PATTERN:0]        end_hot,
  output logic [MAX_PATTERN-1:0]      star,
  output logic [MAX_PATTERN-1:0]      any_pos,
  output wpm_pkg::byte_t              pat_byte [MAX_PATTERN],
  output logic                        overflow
);
  import wpm_pkg::*;

  logic full;

  assign full = end_hot[MAX_PATTERN];

  always_ff @(posedge clk) begin
    if (rst) begin
      mask     <= '0;
      end_hot  <= {{MAX_PATTERN{1'b0}}, 1'b1};
      overflow <= 1'b0;
    end else if (cmd.clear) begin
      mask     <= '0;
      end_hot  <= {{MAX_PATTERN{1'b0}}, 1'b1};
      overflow <= 1'b0;
    end else if (cmd.append) begin
      if (full) begin
        overflow <= 1'b1;
      end else begin
        mask    <= mask | end_hot[MAX_PATTERN-1:0];
        end_hot <= {end_hot[MAX_PATTERN-1:0], 1'b0};
      end
    end
  end

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pos
    always_ff @(posedge clk) begin
      if (cmd.append && !cmd.clear && end_hot[i]) begin
        pat_byte[i] <= cmd.symbol;
      end
    end
    assign star[i]    = (pat_byte[i] == STAR_BYTE);
    assign any_pos[i] = (pat_byte[i] == ANY_BYTE);
  end

endmodule

`default_nettype wire

[hw/rtl/wpm_closure.sv]
// ----------------------------------------------------------------------------
// wpm_closure
// Parallel-prefix scan that spreads active positions forward across runs of
// star positions (empty star match).
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_closure #(
  parameter int N = 129
) (
  input  logic [N-1:0] seed,
  input  logic [N-2:0] pass,
  output logic [N-1:0] closed
);

  localparam int Levels = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] gen [0:Levels];
  logic [N-1:0] prp [0:Levels];

  assign gen[0] = seed;
  assign prp[0] = {pass, 1'b0};

  for (genvar lv = 0; lv < Levels; lv++) begin : g_lvl
    localparam int D = 1 << lv;
    for (genvar j = 0; j < N; j++) begin : g_bit
      if (j >= D) begin : g_comb
        assign gen[lv+1][j] = gen[lv][j] | (prp[lv][j] & gen[lv][j-D]);
        assign prp[lv+1][j] = prp[lv][j] & prp[lv][j-D];
      end else begin : g_keep
        assign gen[lv+1][j] = gen[lv][j];
        assign prp[lv+1][j] = prp[lv][j];
      end
    end
  end

  assign closed = gen[Levels];

endmodule

`default_nettype wire

[hw/rtl/wpm_step.sv]
// ----------------------------------------------------------------------------
// wpm_step
// Bit-parallel advance of the active position vector by one text byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_step #(
  parameter int MAX_PATTERN = 128
) (
  input  logic [MAX_PATTERN:0]     closed,
  input  logic [MAX_PATTERN-1:0]   mask,
  input  logic [MAX_PATTERN-1:0]   star,
  input  logic [MAX_PATTERN-1:0]   any_pos,
  input  wpm_pkg::byte_t           pat_byte [MAX_PATTERN],
  input  wpm_pkg::byte_t           symbol,
  output logic [MAX_PATTERN:0]     next_active
);
  import wpm_pkg::*;

  logic [MAX_PATTERN-1:0] act;
  logic [MAX_PATTERN-1:0] adv;
  logic [MAX_PATTERN-1:0] stay;

  assign act = closed[MAX_PATTERN-1:0] & mask;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pos
    assign stay[i] = act[i] & star[i];
    assign adv[i]  = act[i] & !star[i] & (any_pos[i] | (pat_byte[i] == symbol));
  end

  assign next_active = {adv, 1'b0} | {1'b0, stay};

endmodule

`default_nettype wire

[hw/rtl/wildcard_pattern_matcher_core.sv]
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_core
// Streams pattern and text bytes and reports whole-text wildcard matches.
// ----------------------------------------------------------------------------
// Each input transfer carries a mode in tuser (clear, append pattern byte,
// text byte, end of text) and a byte in tdata. One item is taken every clock
// cycle unless an end-of-text item waits on a held result; every pattern position
// updates in parallel through one star-closure scan of ceil(log2(MAX_PATTERN+1))
// levels between the active vector register and the step logic. Only end of text
// yields a result transfer, through the result register; it waits only while
// the result register is still held by the downstream side. Pattern bytes beyond
// MAX_PATTERN are dropped and flagged as too_long until the next clear. Any clear
// or append restarts the current text.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_pattern_matcher_core #(
  parameter int MAX_PATTERN = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] symbol
  input  logic [1:0] s_tuser,   // [1:0] mode
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] matched, [1] too_long, [7:2] zero
);
  import wpm_pkg::*;

  logic       in_valid;
  mode_t      in_mode;
  byte_t      in_sym;
  logic       out_free;
  logic       fire;
  logic       matched;
  logic       too_long;

  logic [MAX_PATTERN:0]   active;
  logic [MAX_PATTERN:0]   active_next;
  logic [MAX_PATTERN:0]   closed;
  logic [MAX_PATTERN:0]   stepped;
  logic [MAX_PATTERN-1:0] mask;
  logic [MAX_PATTERN:0]   end_hot;
  logic [MAX_PATTERN-1:0] star;
  logic [MAX_PATTERN-1:0] any_pos;
  byte_t                  pat_byte [MAX_PATTERN];
  logic                   overflow;
  pat_cmd_t               cmd;

  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_valid && ((in_mode != MODE_END) || out_free);
  assign s_tready = !in_valid || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_mode <= s_tuser;
      in_sym  <= s_tdata;
    end
  end

  assign cmd.clear  = fire && (in_mode == MODE_CLEAR);
  assign cmd.append = fire && (in_mode == MODE_APPEND);
  assign cmd.symbol = in_sym;

  wpm_pattern #(.MAX_PATTERN(MAX_PATTERN)) u_pattern (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .mask     (mask),
    .end_hot  (end_hot),
    .star     (star),
    .any_pos  (any_pos),
    .pat_byte (pat_byte),
    .overflow (overflow)
  );

  wpm_closure #(.N(MAX_PATTERN + 1)) u_closure (
    .seed   (active),
    .pass   (star & mask),
    .closed (closed)
  );

  wpm_step #(.MAX_PATTERN(MAX_PATTERN)) u_step (
    .closed      (closed),
    .mask        (mask),
    .star        (star),
    .any_pos     (any_pos),
    .pat_byte    (pat_byte),
    .symbol      (in_sym),
    .next_active (stepped)
  );

  always_comb begin
    active_next = active;
    if (fire) begin
      case (in_mode)
        MODE_TEXT: active_next = stepped;
        default:   active_next = {{MAX_PATTERN{1'b0}}, 1'b1};
      endcase
    end
  end

  // active vector kept unclosed; closure applied where it is read
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= {{MAX_PATTERN{1'b0}}, 1'b1};
    end else begin
      active <= active_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && (in_mode == MODE_END)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (in_mode == MODE_END)) begin
      matched  <= |(closed & end_hot);
      too_long <= overflow;
    end
  end

  assign m_tdata = {6'b0, too_long, matched};

endmodule

`default_nettype wire

[hw/rtl/wpm_checker.sv]
// ----------------------------------------------------------------------------
// wpm_checker
// Port-level checks for the wildcard pattern matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // no result pending right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // input only stalls while a result is held downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a held result");

  // held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:2] == 6'd0))
    else $error("result padding not zero");

endmodule

bind wildcard_pattern_matcher_core wpm_checker u_wpm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wildcard pattern matcher core.
// ----------------------------------------------------------------------------
// Pattern bytes, text bytes, clears and end-of-text markers are streamed into
// the core. A behavioral copy of the matcher (pattern memory, active position
// vector closed over stars, sticky overflow) predicts the verdict of every
// end-of-text transfer. Each result transfer is checked field by field
// against the oldest pending verdict. Directed tests cover empty patterns,
// star-only patterns, '?' and literal bytes, appends in the middle of a text
// and pattern overflow. Random sessions load a pattern, then send texts built
// from it (some mutated) or free texts, mixed with noise transfers. Both
// sides of the core stall at random in the first two of three random phases; the third runs with no idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import wpm_pkg::*;

  localparam int MAX_PAT   = 128;
  localparam int STALL_MAX = 4000;
  localparam int DRAIN_CYC = 16;
  localparam int MAX_SHOWN = 100;

  localparam byte_t CH_A = "a";
  localparam byte_t CH_B = "b";
  localparam byte_t CH_C = "c";

  typedef struct packed {
    logic too_long;
    logic matched;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] symbol
  logic [1:0] s_tuser = 2'b00;   // [1:0] mode
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [0] matched, [1] too_long, [7:2] zero

  // matcher state as predicted
  byte_t            pat_mem [MAX_PAT];
  int unsigned      pat_len;
  logic [MAX_PAT:0] live;
  logic             pat_over;

  verdict_t verdict_q[$];
  int       err_count = 0;
  int       items_sent = 0;
  int       send_idle_pct = 38;
  int       recv_idle_pct = 81;
  int       stall_cycles = 0;

  wildcard_pattern_matcher_core #(
    .MAX_PATTERN(MAX_PAT)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [MAX_PAT:0] star_close(logic [MAX_PAT:0] v);
    for (int i = 0; i < pat_len; i++) begin
      if (v[i] && pat_mem[i] == STAR_BYTE) v[i+1] = 1'b1;
    end
    return v;
  endfunction

  function automatic void restart_match();
    logic [MAX_PAT:0] v;
    v = '0;
    v[0] = 1'b1;
    live = star_close(v);
  endfunction

  function automatic void advance_text(byte_t c);
    logic [MAX_PAT:0] nxt;
    nxt = '0;
    for (int i = 0; i < pat_len; i++) begin
      if (live[i]) begin
        if (pat_mem[i] == STAR_BYTE) nxt[i] = 1'b1;
        else if (pat_mem[i] == ANY_BYTE || pat_mem[i] == c) nxt[i+1] = 1'b1;
      end
    end
    live = star_close(nxt);
  endfunction

  function automatic void track_item(mode_t m, byte_t s);
    verdict_t v;
    case (m)
      MODE_CLEAR: begin
        pat_len = 0;
        pat_over = 1'b0;
        restart_match();
      end
      MODE_APPEND: begin
        if (pat_len < MAX_PAT) begin
          pat_mem[pat_len] = s;
          pat_len++;
        end else begin
          pat_over = 1'b1;
        end
        restart_match();
      end
      MODE_TEXT: advance_text(s);
      default: begin
        v.matched = live[pat_len];
        v.too_long = pat_over;
        verdict_q.insert(verdict_q.size(), v);
        restart_match();
      end
    endcase
  endfunction

  // ------------------------------------------------------------------ driving

  task automatic send_item(mode_t m, byte_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= m;
    s_tdata <= s;
    do @(posedge clk); while (!s_tready);
    track_item(m, s);
    items_sent++;
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ----------------------------------------------------------------- checking

  task automatic report_mismatch(string what, int exp_val, int got_val);
    if (err_count < MAX_SHOWN)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_val,
               got_val);
    err_count++;
  endtask

  always @(posedge clk) begin
    verdict_t v;
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result transfer", 0, int'(m_tdata));
      end else begin
        v = verdict_q.pop_front();
        if (m_tdata[0] !== v.matched)
          report_mismatch("matched", int'(v.matched), int'(m_tdata[0]));
        if (m_tdata[1] !== v.too_long)
          report_mismatch("too_long", int'(v.too_long), int'(m_tdata[1]));
        if (m_tdata[7:2] !== 6'd0)
          report_mismatch("tdata padding", 0, int'(m_tdata[7:2]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("timeout: no transfer for %0d cycles", STALL_MAX);
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic byte_t pick_text_byte();
    int r;
    r = $urandom_range(99);
    if (r < 27) return CH_A;
    if (r < 54) return CH_B;
    if (r < 80) return CH_C;
    return byte_t'($urandom);
  endfunction

  function automatic byte_t pick_pattern_byte();
    int r;
    r = $urandom_range(99);
    if (r < 25) return STAR_BYTE;
    if (r < 45) return ANY_BYTE;
    if (r < 90) return pick_text_byte();
    return byte_t'($urandom);
  endfunction

  task automatic test_empty_pattern();
    send_item(MODE_CLEAR, 8'h00);
    send_item(MODE_END, 8'hFF);
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_END, 8'h00);
  endtask

  task automatic test_star_only();
    send_item(MODE_APPEND, STAR_BYTE);
    send_item(MODE_END, 8'h55);
    send_item(MODE_TEXT, 8'hFF);
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_END, 8'hAA);
    send_item(MODE_CLEAR, 8'hFF);
  endtask

  task automatic test_wildcards();
    send_item(MODE_APPEND, CH_A);
    send_item(MODE_APPEND, ANY_BYTE);
    send_item(MODE_APPEND, STAR_BYTE);
    send_item(MODE_APPEND, CH_B);
    send_item(MODE_TEXT, CH_A);
    send_item(MODE_TEXT, 8'hFF);
    send_item(MODE_TEXT, CH_B);
    send_item(MODE_END, 8'h00);
    send_item(MODE_TEXT, CH_A);
    send_item(MODE_TEXT, CH_B);
    send_item(MODE_END, 8'h00);
  endtask

  task automatic test_append_during_text();
    send_item(MODE_TEXT, CH_A);
    send_item(MODE_APPEND, CH_C);
    send_item(MODE_TEXT, CH_A);
    send_item(MODE_TEXT, 8'h00);
    send_item(MODE_TEXT, CH_B);
    send_item(MODE_TEXT, CH_C);
    send_item(MODE_END, 8'h00);
  endtask

  task automatic test_overflow();
    send_item(MODE_CLEAR, 8'h00);
    repeat (MAX_PAT) send_item(MODE_APPEND, ANY_BYTE);
    send_item(MODE_END, 8'h00);
    repeat (2) send_item(MODE_APPEND, pick_pattern_byte());
    repeat (MAX_PAT) send_item(MODE_TEXT, byte_t'($urandom));
    send_item(MODE_END, 8'h00);
    send_item(MODE_END, 8'hFF);
    send_item(MODE_CLEAR, 8'h00);
    send_item(MODE_END, 8'h00);
  endtask

  // clear, load a pattern, then run a few texts against it
  task automatic run_session();
    byte_t pat[$];
    byte_t txt[$];
    int    plen;
    int    r;
    int    idx;
    pat.delete();
    send_item(MODE_CLEAR, byte_t'($urandom));
    r = $urandom_range(99);
    if (r < 85) plen = $urandom_range(0, 8);
    else if (r < 97) plen = $urandom_range(9, 40);
    else plen = $urandom_range(MAX_PAT - 8, MAX_PAT + 4);
    for (int k = 0; k < plen; k++) begin
      pat.insert(pat.size(), pick_pattern_byte());
      send_item(MODE_APPEND, pat[k]);
    end
    repeat ($urandom_range(1, 4)) begin
      txt.delete();
      if ($urandom_range(99) < 60) begin
        foreach (pat[j]) begin
          if (pat[j] == STAR_BYTE)
            repeat ($urandom_range(0, 3)) txt.insert(txt.size(), pick_text_byte());
          else if (pat[j] == ANY_BYTE) txt.insert(txt.size(), byte_t'($urandom));
          else txt.insert(txt.size(), pat[j]);
        end
        if ($urandom_range(99) < 30) begin
          r = $urandom_range(2);
          if (r == 0 && txt.size() > 0) begin
            idx = $urandom_range(txt.size() - 1);
            txt[idx] = txt[idx] ^ byte_t'(1 << $urandom_range(7));
          end else if (r == 1) begin
            txt.insert($urandom_range(txt.size()), pick_text_byte());
          end else if (txt.size() > 0) begin
            txt.delete($urandom_range(txt.size() - 1));
          end
        end
      end else begin
        repeat ($urandom_range(0, 10)) txt.insert(txt.size(), pick_text_byte());
      end
      foreach (txt[j]) begin
        if ($urandom_range(999) < 5) send_item(MODE_APPEND, pick_pattern_byte());
        send_item(MODE_TEXT, txt[j]);
      end
      send_item(MODE_END, byte_t'($urandom));
    end
  endtask

  task automatic test_random(int n_items, int s_pct, int r_pct);
    int target;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(99) < 90) begin
        run_session();
      end else begin
        repeat ($urandom_range(1, 10)) send_item(mode_t'($urandom_range(3)), byte_t'($urandom));
      end
    end
  endtask

  initial begin
    pat_len = 0;
    pat_over = 1'b0;
    restart_match();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_pattern();
    test_star_only();
    test_wildcards();
    test_append_during_text();
    test_overflow();
    test_random(500, 38, 81);
    test_random(500, 81, 38);
    test_random(500, 0, 0);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
